### rtl/core/address_range_region_table_top_macros.svh
// Assertion macros used by the top file to check the region table.
`ifndef ADDRESS_RANGE_REGION_TABLE_TOP_MACROS_SVH
`define ADDRESS_RANGE_REGION_TABLE_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ARRT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ARRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define ARRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/arrt_pkg.sv
package arrt_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 32;
  localparam int unsigned ADDR_W            = 64;
  localparam int unsigned IDX_OUT_W         = 5;
  localparam int unsigned CNT_OUT_W         = 6;
  localparam int unsigned REQ_W             = 2;
  localparam int unsigned S_TDATA_W         = 192;
  localparam int unsigned M_TDATA_W         = 80;
  localparam int unsigned RES_W             = 77;

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_ABORT  = 2'd3
  } req_e;

  // Write command broadcast to every cell of the table.
  typedef struct packed {
    logic              load;   // append into the slot equal to the count
    logic              shift;  // full table: each cell takes its upper neighbor, the top cell the new region
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } wr_t;

  // Lookup token that walks the cell chain one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] off;
  } tok_t;

  // Result transaction, hit in the lowest bit.
  typedef struct packed {
    logic                 evict;
    logic [CNT_OUT_W-1:0] cnt;
    logic [ADDR_W-1:0]    off;
    logic [IDX_OUT_W-1:0] idx;
    logic                 hit;
  } res_t;

endpackage

### rtl/core/arrt_cell.sv
module arrt_cell #(
  parameter int unsigned TABLE_ENTRIES = 32,
  parameter int unsigned CELL_IDX      = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  arrt_pkg::wr_t                            wr_i,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]       count_i,
  input  logic [arrt_pkg::ADDR_W-1:0]              nb_base_i,
  input  logic [arrt_pkg::ADDR_W-1:0]              nb_size_i,
  input  arrt_pkg::tok_t                           tok_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]         idx_i,
  output logic [arrt_pkg::ADDR_W-1:0]              base_o,
  output logic [arrt_pkg::ADDR_W-1:0]              size_o,
  output arrt_pkg::tok_t                           tok_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0]         idx_o
);
  import arrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] size_q;
  logic [ADDR_W-1:0] diff;
  logic              live;
  logic              match;
  tok_t              tok_d;
  tok_t              tok_q;
  logic [IDX_W-1:0]  idx_d;
  logic [IDX_W-1:0]  idx_q;

  // The entry is stored data: no reset, written only by insert commands.
  always_ff @(posedge clk_i) begin
    if (wr_i.shift) begin
      base_q <= nb_base_i;
      size_q <= nb_size_i;
    end else if (wr_i.load && (count_i == MY_CNT)) begin
      base_q <= wr_i.base;
      size_q <= wr_i.size;
    end
  end

  // The end address is never formed, so a region that runs past the top of
  // the address space cannot wrap.
  always_comb begin
    diff  = tok_i.addr - base_q;
    live  = count_i > MY_CNT;
    match = tok_i.valid && !tok_i.found && live &&
            (tok_i.addr >= base_q) && (diff < size_q);
    tok_d = tok_i;
    idx_d = idx_i;
    if (match) begin
      tok_d.found = 1'b1;
      tok_d.off   = diff;
      idx_d       = MY_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      idx_q <= '0;
    end else begin
      tok_q <= tok_d;
      idx_q <= idx_d;
    end
  end

  assign base_o = base_q;
  assign size_o = size_q;
  assign tok_o  = tok_q;
  assign idx_o  = idx_q;

endmodule

### rtl/core/address_range_region_table_top.sv
// Channel   | Direction | Signals                                 | Contents
// ----------+-----------+-----------------------------------------+-------------------------------
// s_axis    | in        | tvalid, tready, tuser[1:0], tdata[191:0] | request kind; base, size, addr
// m_axis    | out       | tvalid, tready, tdata[79:0]             | hit, index, offset, count, evict
//
// Begin, insert and abort requests finish in the cycle they are accepted, so
// they can be taken back to back while the output drains.
// A lookup holds off new requests until its query token leaves the chain: the token
// walks the cell chain one cell per cycle, so the chain length sets how long it takes.
// Reset is asynchronous and active low; the stored regions are not cleared.
// A stalled output holds one result in the output register and one more in a hold
// register; the input then stops taking transactions, as it does during a lookup.
module address_range_region_table_top #(
  parameter int unsigned TABLE_ENTRIES = arrt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tuser: req_type[1:0]
  input  logic [arrt_pkg::REQ_W-1:0]         s_axis_tuser,
  // tdata: region_base[63:0], region_size[127:64], query_address[191:128]
  input  logic [arrt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: hit[0], match_index[5:1], offset_in_region[69:6],
  //        entry_count[75:70], evicted_oldest[76], zero fill [79:77]
  output logic [arrt_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import arrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HOLD
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [CNT_W-1:0]  saved_q;
  logic [CNT_W-1:0]  saved_d;
  logic              out_valid_q;
  res_t              out_q;
  res_t              hold_q;
  res_t              imm_res;
  res_t              look_res;

  req_e              req;
  logic              acc;
  logic              out_free;
  logic              out_load;
  logic              full;
  wr_t               wr;
  logic [ADDR_W-1:0] in_base;
  logic [ADDR_W-1:0] in_size;
  logic [ADDR_W-1:0] in_addr;

  // Chain wiring: position i feeds cell i, position TABLE_ENTRIES leaves the chain.
  tok_t              tok_c  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]  idx_c  [TABLE_ENTRIES+1];
  logic [ADDR_W-1:0] base_c [TABLE_ENTRIES];
  logic [ADDR_W-1:0] size_c [TABLE_ENTRIES];

  assign req      = req_e'(s_axis_tuser);
  assign in_base  = s_axis_tdata[ADDR_W-1:0];
  assign in_size  = s_axis_tdata[2*ADDR_W-1:ADDR_W];
  assign in_addr  = s_axis_tdata[3*ADDR_W-1:2*ADDR_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (count_q == FULL);

  // The output register takes a new result whenever the sequencer has one
  // ready and the register is free in this cycle.
  assign out_load = out_free &&
                    ((acc && (req != REQ_LOOKUP)) ||
                     ((state_q == ST_SEARCH) && tok_c[TABLE_ENTRIES].valid) ||
                     (state_q == ST_HOLD));

  // An insert into a full table drops entry 0 by shifting the whole row down
  // one cell; the new region enters at the top end of the chain.
  assign wr.load  = acc && (req == REQ_INSERT) && !full;
  assign wr.shift = acc && (req == REQ_INSERT) && full;
  assign wr.base  = in_base;
  assign wr.size  = in_size;

  // A new lookup enters the chain at cell 0 with no match yet.
  assign tok_c[0] = '{valid: acc && (req == REQ_LOOKUP), found: 1'b0,
                      addr: in_addr, off: '0};
  assign idx_c[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [ADDR_W-1:0] nb_base;
    logic [ADDR_W-1:0] nb_size;

    if (i == TABLE_ENTRIES - 1) begin : g_top
      assign nb_base = in_base;
      assign nb_size = in_size;
    end else begin : g_mid
      assign nb_base = base_c[i+1];
      assign nb_size = size_c[i+1];
    end

    arrt_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .CELL_IDX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (wr),
      .count_i   (count_q),
      .nb_base_i (nb_base),
      .nb_size_i (nb_size),
      .tok_i     (tok_c[i]),
      .idx_i     (idx_c[i]),
      .base_o    (base_c[i]),
      .size_o    (size_c[i]),
      .tok_o     (tok_c[i+1]),
      .idx_o     (idx_c[i+1])
    );
  end

  // Count bookkeeping and the result of requests that finish at once.
  always_comb begin
    count_d = count_q;
    saved_d = saved_q;
    imm_res = '0;
    unique case (req)
      REQ_BEGIN: begin
        saved_d = count_q;
        count_d = '0;
      end
      REQ_INSERT: begin
        if (!full) begin
          count_d = count_q + CNT_W'(1);
        end
        imm_res.evict = full;
      end
      REQ_LOOKUP: begin
        count_d = count_q;
      end
      REQ_ABORT: begin
        count_d = saved_q;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    imm_res.cnt = CNT_OUT_W'(count_d);
  end

  // A token leaving the chain carries a zero index and offset unless it hit.
  always_comb begin
    look_res       = '0;
    look_res.hit   = tok_c[TABLE_ENTRIES].found;
    look_res.idx   = IDX_OUT_W'(idx_c[TABLE_ENTRIES]);
    look_res.off   = tok_c[TABLE_ENTRIES].off;
    look_res.cnt   = CNT_OUT_W'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      saved_q <= '0;
    end else if (acc) begin
      count_q <= count_d;
      saved_q <= saved_d;
    end
  end

  // Sequencer with the output register and the hold register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      hold_q      <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (req == REQ_LOOKUP) begin
              state_q <= ST_SEARCH;
            end else if (out_free) begin
              out_q <= imm_res;
            end else begin
              hold_q  <= imm_res;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_SEARCH: begin
          if (tok_c[TABLE_ENTRIES].valid) begin
            if (out_free) begin
              out_q   <= look_res;
              state_q <= ST_IDLE;
            end else begin
              hold_q  <= look_res;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_q   <= hold_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - RES_W)'(0), out_q};

`include "address_range_region_table_top_macros.svh"

  // The count can never pass the table size, whatever the request mix.
  `ARRT_ASSERT_ALWAYS(a_count_bound, count_q <= FULL, "entry count exceeds table size")

  // A lookup token may leave the chain only while the sequencer waits for it.
  `ARRT_ASSERT_IMPL(a_token_in_search, tok_c[TABLE_ENTRIES].valid, state_q == ST_SEARCH, "lookup token left the chain outside a search")

  // The hold register is used only when the output register is occupied.
  `ARRT_ASSERT_IMPL(a_hold_behind_out, state_q == ST_HOLD, out_valid_q, "hold register filled while output register empty")

  // An insert into a full table keeps the table full.
  `ARRT_ASSERT_NEXT(a_evict_stays_full, acc && (req == REQ_INSERT) && full, count_q == FULL, "eviction changed the entry count")

endmodule

### tb/region_table_checker.sv
module region_table_checker
  import arrt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [REQ_W-1:0]     s_user_i,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [M_TDATA_W-1:0] m_data_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES    = DEF_TABLE_ENTRIES;
  localparam int unsigned REPORT_MAX = 10;

  logic [ADDR_W-1:0] region_base_tbl [ENTRIES];
  logic [ADDR_W-1:0] region_size_tbl [ENTRIES];
  int unsigned       live_count;
  int unsigned       saved_count;
  res_t              expected_results [$];

  // Updates the shadow table and returns the result the request should produce.
  function automatic res_t apply_request(req_e kind, logic [ADDR_W-1:0] base,
                                         logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] addr);
    res_t r;
    r = '0;
    case (kind)
      REQ_BEGIN: begin
        saved_count = live_count;
        live_count  = 0;
      end
      REQ_INSERT: begin
        if (live_count < ENTRIES) begin
          region_base_tbl[live_count] = base;
          region_size_tbl[live_count] = size;
          live_count++;
        end else begin
          for (int i = 0; i < ENTRIES - 1; i++) begin
            region_base_tbl[i] = region_base_tbl[i+1];
            region_size_tbl[i] = region_size_tbl[i+1];
          end
          region_base_tbl[ENTRIES-1] = base;
          region_size_tbl[ENTRIES-1] = size;
          r.evict = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        // The difference below never wraps because the base is checked first.
        for (int i = 0; i < live_count; i++) begin
          if (!r.hit && addr >= region_base_tbl[i] &&
              (addr - region_base_tbl[i]) < region_size_tbl[i]) begin
            r.hit = 1'b1;
            r.idx = IDX_OUT_W'(i);
            r.off = addr - region_base_tbl[i];
          end
        end
      end
      default: begin
        live_count = saved_count;
      end
    endcase
    r.cnt = CNT_OUT_W'(live_count);
    return r;
  endfunction

  function automatic void note_failure(string msg);
    if (errors_o < REPORT_MAX) $display("[%0t] %s", $realtime, msg);
    errors_o++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      expected_results.delete();
      live_count  = 0;
      saved_count = 0;
      pending_o   = 0;
      errors_o    = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        expected_results.push_back(apply_request(req_e'(s_user_i), s_data_i[63:0],
                                                 s_data_i[127:64], s_data_i[191:128]));
      end
      if (m_valid_i && m_ready_i) begin
        got = res_t'(m_data_i[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with none outstanding: tdata=%h", m_data_i));
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit || got.idx !== want.idx || got.off !== want.off ||
              got.cnt !== want.cnt || got.evict !== want.evict ||
              m_data_i[M_TDATA_W-1:RES_W] !== '0) begin
            note_failure($sformatf(
              "exp hit=%0b idx=%0d off=%h cnt=%0d evict=%0b, got hit=%0b idx=%0d off=%h cnt=%0d evict=%0b fill=%b",
              want.hit, want.idx, want.off, want.cnt, want.evict,
              got.hit, got.idx, got.off, got.cnt, got.evict, m_data_i[M_TDATA_W-1:RES_W]));
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arrt_pkg::*;

  // Cycles without any transaction on either channel before the run is declared hung.
  // The slowest legitimate quiet stretch is the deliberate output hold-off.
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS = 1720;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned DRAIN_AT     = 900;
  localparam int unsigned POOL_DEPTH   = 64;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [REQ_W-1:0]     s_axis_tuser;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int unsigned results_pending;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          backlog_done;

  // Recently inserted regions, used only to aim lookups at interesting addresses.
  logic [ADDR_W-1:0] pool_base [$];
  logic [ADDR_W-1:0] pool_size [$];

  address_range_region_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  region_table_checker checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_i (s_axis_tready),
    .s_user_i  (s_axis_tuser),
    .s_data_i  (s_axis_tdata),
    .m_valid_i (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_i  (m_axis_tdata),
    .pending_o (results_pending),
    .errors_o  (fail_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Two windows in which neither side idles: one covers the output hold-off so the
  // sender keeps pushing while the block backs up, the other is a plain full-rate run.
  function automatic bit calm_phase();
    return (items_sent >= HOLD_AT && items_sent < HOLD_AT + 150) ||
           (items_sent >= 1200 && items_sent < 1350);
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap(int unsigned long_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(8, long_max);
  endfunction

  function automatic logic [ADDR_W-1:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0, 1, 2: return ADDR_W'($urandom_range(0, 4095));
      3:       return ALL_ONES - ADDR_W'($urandom_range(0, 65535));
      4:       return '0;
      5:       return ALL_ONES;
      default: return rnd64();
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return ADDR_W'(1);
      2, 3, 4:    return ADDR_W'($urandom_range(1, 4096));
      5:          return ALL_ONES;
      default:    return rnd64() >> $urandom_range(0, 63);
    endcase
  endfunction

  // Aims at the inside, the edges, or just outside either end of a known region, now and then at a random base.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned j;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    if (pool_base.size() == 0 || $urandom_range(0, 99) < 15) return pick_base();
    j = $urandom_range(0, pool_base.size() - 1);
    b = pool_base[j];
    s = pool_size[j];
    case ($urandom_range(0, 5))
      0:       return (s == 0) ? b : b + (rnd64() % s);
      1:       return b;
      2:       return b + s - 1;
      3:       return b + s;
      4:       return b - 1;
      default: return (s == 0) ? b : b + (rnd64() % s);
    endcase
  endfunction

  // Offers one request after a random gap and returns at the falling edge after
  // the transaction is taken.
  task automatic send_req(req_e kind, logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                          logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = calm_phase() ? 0 : pick_gap(40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {addr, size, base};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
    if (kind == REQ_INSERT) begin
      pool_base.push_back(base);
      pool_size.push_back(size);
      if (pool_base.size() > POOL_DEPTH) begin
        void'(pool_base.pop_front());
        void'(pool_size.pop_front());
      end
    end
  endtask

  task automatic insert_req(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    send_req(REQ_INSERT, base, size, rnd64());
  endtask

  task automatic lookup_req(logic [ADDR_W-1:0] addr);
    send_req(REQ_LOOKUP, rnd64(), rnd64(), addr);
  endtask

  task automatic control_req(req_e kind);
    send_req(kind, rnd64(), rnd64(), rnd64());
  endtask

  // Stops offering until every predicted result has come back. At least one
  // falling edge always passes so the valid low is never overwritten in the same step.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off once the run is under
  // way so the output and hold registers fill and the input stalls.
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!backlog_done && items_sent >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready <= 1'b1;
        backlog_done = 1'b1;
      end else begin
        stall = calm_phase() ? 0 : pick_gap(80);
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned r;
    int unsigned n;
    bit          mid_drained;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = REQ_BEGIN;
    s_axis_tdata  = '0;
    items_sent    = 0;
    idle_cycles   = 0;
    backlog_done  = 1'b0;
    mid_drained   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. The empty table misses, and an abort with no begin before
    // it falls back to the count saved at reset.
    lookup_req(ALL_ONES);
    control_req(REQ_ABORT);
    control_req(REQ_BEGIN);
    // A zero-size region contains nothing, not even its own base.
    insert_req('0, '0);
    lookup_req('0);
    // The largest region from zero stops one short of the top address.
    insert_req('0, ALL_ONES);
    lookup_req('0);
    lookup_req(ALL_ONES);
    // A region running past the top of the address space is not wrapped.
    insert_req(ALL_ONES - 64'hFF, ALL_ONES);
    lookup_req(ALL_ONES);
    lookup_req(ALL_ONES - 64'h100);
    insert_req(ALL_ONES, 64'd1);
    lookup_req(ALL_ONES);
    // Rebuild that is abandoned: row zero stays overwritten after the abort.
    control_req(REQ_BEGIN);
    insert_req(64'h1000, 64'h100);
    lookup_req(64'h10FF);
    lookup_req(64'h1100);
    lookup_req(64'h0FFF);
    control_req(REQ_ABORT);
    lookup_req(64'h1000);
    // A second begin saves the already emptied count.
    control_req(REQ_BEGIN);
    control_req(REQ_BEGIN);
    control_req(REQ_ABORT);
    insert_req(rnd64(), rnd64());
    lookup_req(rnd64());
    wait_drain();

    // Random part: mostly rebuilds followed by aimed lookups, some of them long
    // enough to fill the table and push out the oldest rows, plus some noise.
    while (items_sent < RANDOM_ITEMS) begin
      if (!mid_drained && items_sent >= DRAIN_AT) begin
        wait_drain();
        mid_drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        control_req(REQ_BEGIN);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
        repeat (n) insert_req(pick_base(), pick_size());
        if ($urandom_range(0, 4) == 0) control_req(REQ_ABORT);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 8)) lookup_req(pick_address());
      end else if (r < 92) begin
        repeat ($urandom_range(1, 6)) insert_req(pick_base(), pick_size());
      end else begin
        send_req(req_e'($urandom_range(0, 3)), rnd64(), rnd64(), rnd64());
      end
    end

    // Let everything drain, then allow a lookup's worth of cycles for strays.
    wait_drain();
    repeat (2 * DEF_TABLE_ENTRIES + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/arrt_pkg.sv
rtl/core/arrt_cell.sv
rtl/core/address_range_region_table_top.sv
tb/region_table_checker.sv
tb/tb.sv
